// ----- design/ipcp_pkg.sv -----
// Shared types, codes and limits of the IPv4 CIDR / endpoint parser.
`default_nettype none
package ipcp_pkg;

    localparam int OCTET_MAX     = 255;
    localparam int PREFIX_MAX    = 32;
    localparam int PORT_MAX      = 65535;
    localparam int OCTET_DIGITS  = 3;
    localparam int PORT_DIGITS   = 5;
    localparam int PREFIX_DIGITS = 2;
    localparam int OCTETS        = 4;

    localparam int FIELD_W = 17;
    localparam int CFG_W   = 6;

    localparam logic ACT_CHAR = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef logic [0:0]       t_cfg_idx;
    typedef logic [CFG_W-1:0] t_cfg_data;

    localparam t_cfg_idx CFG_ENDPOINT_MODE  = 1'b0;
    localparam t_cfg_idx CFG_DEFAULT_PREFIX = 1'b1;

    typedef enum logic [1:0] {
        PH_ADDR   = 2'd0,
        PH_PREFIX = 2'd1,
        PH_PORT   = 2'd2
    } t_phase;

    typedef struct packed {
        logic       action;
        logic [7:0] character;
    } t_item;

    typedef struct packed {
        logic       endpoint_mode;
        logic [5:0] default_prefix;   // already saturated to 32
    } t_cfg;

    typedef struct packed {
        logic        valid_res;
        logic [31:0] address_value;
        logic [5:0]  prefix_length;
        logic [15:0] port_number;
    } t_res;

endpackage
`default_nettype wire

// ----- design/ipcp_in_if.sv -----
// Character item channel: valid/ready with action and character.
`default_nettype none
interface ipcp_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] character;

    modport source (output valid, output action, output character, input ready);
    modport sink   (input valid, input action, input character, output ready);
endinterface
`default_nettype wire

// ----- design/ipcp_res_if.sv -----
// Result item channel: valid/ready with the parsed address, prefix and port.
`default_nettype none
interface ipcp_res_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [31:0] address_value;
    logic [5:0]  prefix_length;
    logic [15:0] port_number;

    modport source (output valid, output valid_res, output address_value,
                    output prefix_length, output port_number, input ready);
    modport sink   (input valid, input valid_res, input address_value,
                    input prefix_length, input port_number, output ready);
endinterface
`default_nettype wire

// ----- design/ipv4_cidr_endpoint_parser_unit.sv -----
// Top level of the IPv4 dotted-quad / CIDR / endpoint parser.
// Text arrives on i_item, one character item per cycle while no end item waits; the
// per-item work is a single digit multiply-accumulate and a few compares between the
// input register and the parse state. An end item closes the text and yields one result
// item on o_res via the input register, then the output register, and waits in the input
// register while a result there is not taken; the output register lets the next text start
// while a result waits. Character items produce no result. Configuration (endpoint mode,
// default prefix) resets to 0 and 32 and should be written only while no text is open.
`default_nettype none
module ipv4_cidr_endpoint_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  ipcp_pkg::t_cfg_idx  i_cfg_index,
    input  ipcp_pkg::t_cfg_data i_cfg_data,
    ipcp_in_if.sink            i_item,
    ipcp_res_if.source         o_res
);
    import ipcp_pkg::*;

    logic  r_in_vld;
    t_item r_in;
    t_cfg  w_cfg;
    t_res  w_res;
    logic  w_free;
    logic  w_adv;
    logic  w_load;
    logic  w_take;

    // a character item never waits on the output side
    assign w_adv  = r_in_vld && (r_in.action == ACT_CHAR || w_free);
    assign w_load = w_adv && r_in.action == ACT_END;
    assign i_item.ready = !r_in_vld || w_adv;
    assign w_take = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.action    <= i_item.action;
            r_in.character <= i_item.character;
        end
    end

    ipcp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ipcp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_item  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    ipcp_out_buf u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_res   (w_res),
        .o_free  (w_free),
        .o_res   (o_res)
    );

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_adv |=> r_in_vld && $stable(r_in))
        else $error("stalled input item lost or changed");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_res.valid)
        else $error("end item gave no result");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.ready |-> !w_load)
        else $error("waiting result overwritten");
endmodule
`default_nettype wire

// ----- design/ipcp_cfg.sv -----
// Configuration registers: endpoint mode and default prefix.
`default_nettype none
module ipcp_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  ipcp_pkg::t_cfg_idx  i_cfg_index,
    input  ipcp_pkg::t_cfg_data i_cfg_data,
    output ipcp_pkg::t_cfg      o_cfg
);
    import ipcp_pkg::*;

    logic       r_mode;
    logic [5:0] r_dflt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_dflt <= 6'(PREFIX_MAX);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ENDPOINT_MODE:  r_mode <= i_cfg_data[0];
                CFG_DEFAULT_PREFIX: begin
                    // saturate once here instead of on every result
                    if (i_cfg_data > 6'(PREFIX_MAX)) r_dflt <= 6'(PREFIX_MAX);
                    else                             r_dflt <= i_cfg_data;
                end
                default: ;
            endcase
        end
    end

    assign o_cfg.endpoint_mode  = r_mode;
    assign o_cfg.default_prefix = r_dflt;
endmodule
`default_nettype wire

// ----- design/ipcp_parse.sv -----
// Parse state and the per-character step; builds the result on an end item.
`default_nettype none
module ipcp_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  ipcp_pkg::t_item i_item,
    input  ipcp_pkg::t_cfg  i_cfg,
    output ipcp_pkg::t_res  o_res
);
    import ipcp_pkg::*;

    t_phase             r_phase, n_phase;
    logic [2:0]         r_octets, n_octets;
    logic [2:0]         r_digits, n_digits;
    logic [FIELD_W-1:0] r_field, n_field;
    logic [31:0]        r_shift, n_shift;
    logic               r_slash, n_slash;
    logic [5:0]         r_pfx, n_pfx;
    logic               r_err, n_err;

    logic               w_is_digit;
    logic [FIELD_W-1:0] w_field_acc;
    logic [2:0]         w_limit;
    logic               w_addr_ok;
    logic               w_pfx_ok;
    logic [31:0]        w_addr_closed;
    logic               w_ok;
    logic               w_end_ok;

    assign w_is_digit    = (i_item.character >= CH_ZERO) && (i_item.character <= CH_NINE);
    // field * 10 + digit
    assign w_field_acc   = {r_field[FIELD_W-4:0], 3'b000} + {r_field[FIELD_W-2:0], 1'b0}
                         + FIELD_W'(i_item.character[3:0]);
    assign w_addr_ok     = (r_digits != 3'd0) && (r_field <= FIELD_W'(OCTET_MAX))
                         && (r_octets == 3'(OCTETS - 1));
    assign w_pfx_ok      = (r_digits != 3'd0) && (r_field <= FIELD_W'(PREFIX_MAX));
    assign w_addr_closed = {r_shift[23:0], r_field[7:0]};

    always_comb begin
        case (r_phase)
            PH_ADDR:   w_limit = 3'(OCTET_DIGITS);
            PH_PREFIX: w_limit = 3'(PREFIX_DIGITS);
            PH_PORT:   w_limit = 3'(PORT_DIGITS);
            default:   w_limit = 3'd0;
        endcase
    end

    // next state for a character item, or the clear after an end item
    always_comb begin
        n_phase  = r_phase;
        n_octets = r_octets;
        n_digits = r_digits;
        n_field  = r_field;
        n_shift  = r_shift;
        n_slash  = r_slash;
        n_pfx    = r_pfx;
        n_err    = r_err;
        w_ok     = 1'b1;
        if (i_item.action == ACT_END) begin
            n_phase  = PH_ADDR;
            n_octets = 3'd0;
            n_digits = 3'd0;
            n_field  = '0;
            n_shift  = '0;
            n_slash  = 1'b0;
            n_pfx    = '0;
            n_err    = 1'b0;
        end else if (!r_err) begin
            if (w_is_digit) begin
                if (r_digits >= w_limit) begin
                    w_ok = 1'b0;
                end else begin
                    n_digits = r_digits + 3'd1;
                    n_field  = w_field_acc;
                end
            end else if (i_item.character == CH_DOT) begin
                if (r_phase != PH_ADDR || r_digits == 3'd0
                        || r_field > FIELD_W'(OCTET_MAX)
                        || r_octets >= 3'(OCTETS - 1)) begin
                    w_ok = 1'b0;
                end else begin
                    n_shift  = w_addr_closed;
                    n_octets = r_octets + 3'd1;
                    n_digits = 3'd0;
                    n_field  = '0;
                end
            end else if (i_item.character == CH_SLASH) begin
                if (r_phase != PH_ADDR || !w_addr_ok) begin
                    w_ok = 1'b0;
                end else begin
                    n_shift  = w_addr_closed;
                    n_octets = 3'(OCTETS);
                    n_digits = 3'd0;
                    n_field  = '0;
                    n_phase  = PH_PREFIX;
                    n_slash  = 1'b1;
                    n_pfx    = '0;
                end
            end else if (i_item.character == CH_COLON) begin
                if (!i_cfg.endpoint_mode || r_phase == PH_PORT) begin
                    w_ok = 1'b0;
                end else if (r_phase == PH_ADDR) begin
                    w_ok = w_addr_ok;
                    if (w_addr_ok) begin
                        n_shift  = w_addr_closed;
                        n_octets = 3'(OCTETS);
                        n_digits = 3'd0;
                        n_field  = '0;
                        n_phase  = PH_PORT;
                    end
                end else begin
                    w_ok = w_pfx_ok;
                    if (w_pfx_ok) begin
                        n_slash  = 1'b1;
                        n_pfx    = r_field[5:0];
                        n_digits = 3'd0;
                        n_field  = '0;
                        n_phase  = PH_PORT;
                    end
                end
            end else begin
                w_ok = 1'b0;
            end
            if (!w_ok) n_err = 1'b1;
        end
    end

    // result for an end item, taken from the state before the clear
    always_comb begin
        o_res.address_value = r_shift;
        o_res.port_number   = '0;
        if (r_slash) o_res.prefix_length = r_pfx;
        else         o_res.prefix_length = i_cfg.default_prefix;
        case (r_phase)
            PH_ADDR: begin
                w_end_ok            = w_addr_ok && !i_cfg.endpoint_mode;
                o_res.address_value = w_addr_closed;
            end
            PH_PREFIX: begin
                w_end_ok            = w_pfx_ok && !i_cfg.endpoint_mode;
                o_res.prefix_length = r_field[5:0];
            end
            PH_PORT: begin
                w_end_ok = i_cfg.endpoint_mode && (r_digits != 3'd0)
                         && (r_field != '0) && (r_field <= FIELD_W'(PORT_MAX));
                o_res.port_number = r_field[15:0];
            end
            default: w_end_ok = 1'b0;
        endcase
        o_res.valid_res = w_end_ok && !r_err;
        if (!o_res.valid_res) begin
            o_res.address_value = '0;
            o_res.prefix_length = '0;
            o_res.port_number   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_ADDR;
            r_octets <= 3'd0;
            r_digits <= 3'd0;
            r_field  <= '0;
            r_shift  <= '0;
            r_slash  <= 1'b0;
            r_pfx    <= '0;
            r_err    <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_octets <= n_octets;
            r_digits <= n_digits;
            r_field  <= n_field;
            r_shift  <= n_shift;
            r_slash  <= n_slash;
            r_pfx    <= n_pfx;
            r_err    <= n_err;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.action == ACT_END |=>
            r_phase == PH_ADDR && r_octets == 3'd0 && r_digits == 3'd0 && !r_err && !r_slash)
        else $error("parse state not cleared after end item");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err && !(i_fire && i_item.action == ACT_END) |=> r_err)
        else $error("error flag dropped before end item");

    a_addr_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_ADDR |-> r_octets == 3'(OCTETS))
        else $error("left address phase without four octets");
endmodule
`default_nettype wire

// ----- design/ipcp_out_buf.sv -----
// Output register holding one result item until the sink takes it.
`default_nettype none
module ipcp_out_buf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  ipcp_pkg::t_res   i_res,
    output logic            o_free,
    ipcp_res_if.source      o_res
);
    import ipcp_pkg::*;

    logic r_vld;
    t_res r_res;

    assign o_free = !r_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) r_res <= i_res;
    end

    assign o_res.valid         = r_vld;
    assign o_res.valid_res     = r_res.valid_res;
    assign o_res.address_value = r_res.address_value;
    assign o_res.prefix_length = r_res.prefix_length;
    assign o_res.port_number   = r_res.port_number;
endmodule
`default_nettype wire

// ----- tb/tb_ipv4_cidr_endpoint_parser_unit.sv -----
// Self-checking testbench of the IPv4 CIDR / endpoint parser: text items in, parse results out.
module tb_ipv4_cidr_endpoint_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ipcp_pkg::*;

    localparam int IDLE_LIMIT   = 3000;
    localparam int PHASE_ITEMS  = 200;
    localparam int RAND_PHASES  = 7;
    localparam int SETTLE_TICKS = 6;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_wr_en;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;

    ipcp_in_if  in_if();
    ipcp_res_if res_if();

    ipv4_cidr_endpoint_parser_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (in_if),
        .o_res       (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- parse predictor ----------------
    logic        cfg_mode;
    logic [5:0]  cfg_dflt;

    t_phase      pr_phase;
    logic [2:0]  pr_octets;
    logic [2:0]  pr_digits;
    logic [16:0] pr_value;
    logic [31:0] pr_addr;
    logic [6:0]  pr_slash_pfx;   // bit 6: slash seen
    bit          pr_bad;

    t_res parse_results_due[$];

    function automatic void restart_text();
        pr_phase     = PH_ADDR;
        pr_octets    = '0;
        pr_digits    = '0;
        pr_value     = '0;
        pr_addr      = '0;
        pr_slash_pfx = '0;
        pr_bad       = 1'b0;
    endfunction

    function automatic bit seal_address();
        if (pr_digits == 0 || pr_value > OCTET_MAX || pr_octets != OCTETS - 1)
            return 1'b0;
        pr_addr   = {pr_addr[23:0], pr_value[7:0]};
        pr_octets = 3'(OCTETS);
        pr_digits = '0;
        pr_value  = '0;
        return 1'b1;
    endfunction

    function automatic bit seal_prefix();
        if (pr_digits == 0 || pr_value > PREFIX_MAX)
            return 1'b0;
        pr_slash_pfx = {1'b1, pr_value[5:0]};
        pr_digits    = '0;
        pr_value     = '0;
        return 1'b1;
    endfunction

    function automatic void parse_item(logic act, logic [7:0] ch);
        bit          ok;
        int          lim;
        logic [5:0]  pfx;
        logic [15:0] port;
        t_res        r;
        ok   = 1'b1;
        port = '0;
        r    = '0;
        if (act == ACT_END) begin
            ok = !pr_bad;
            if (ok) begin
                if (pr_phase == PH_ADDR) begin
                    ok = seal_address() && !cfg_mode;
                end else if (pr_phase == PH_PREFIX) begin
                    ok = seal_prefix() && !cfg_mode;
                end else begin
                    ok = cfg_mode && pr_digits != 0 && pr_value >= 1 && pr_value <= PORT_MAX;
                    port = pr_value[15:0];
                end
            end
            pfx = (cfg_dflt > PREFIX_MAX) ? 6'(PREFIX_MAX) : cfg_dflt;
            if (pr_slash_pfx[6])
                pfx = pr_slash_pfx[5:0];
            if (ok)
                r = '{valid_res: 1'b1, address_value: pr_addr, prefix_length: pfx,
                      port_number: port};
            parse_results_due.insert(parse_results_due.size(), r);
            restart_text();
        end else if (!pr_bad) begin
            if (ch >= CH_ZERO && ch <= CH_NINE) begin
                lim = (pr_phase == PH_ADDR) ? OCTET_DIGITS :
                      (pr_phase == PH_PREFIX) ? PREFIX_DIGITS : PORT_DIGITS;
                if (pr_digits >= lim) begin
                    ok = 1'b0;
                end else begin
                    pr_digits++;
                    pr_value = 17'(pr_value * 10 + (ch - CH_ZERO));
                end
            end else if (ch == CH_DOT) begin
                if (pr_phase != PH_ADDR || pr_digits == 0 || pr_value > OCTET_MAX ||
                    pr_octets >= OCTETS - 1) begin
                    ok = 1'b0;
                end else begin
                    pr_addr = {pr_addr[23:0], pr_value[7:0]};
                    pr_octets++;
                    pr_digits = '0;
                    pr_value  = '0;
                end
            end else if (ch == CH_SLASH) begin
                if (pr_phase != PH_ADDR || !seal_address()) begin
                    ok = 1'b0;
                end else begin
                    pr_phase     = PH_PREFIX;
                    pr_slash_pfx = 7'h40;
                end
            end else if (ch == CH_COLON) begin
                if (!cfg_mode || pr_phase == PH_PORT)
                    ok = 1'b0;
                else if (pr_phase == PH_ADDR)
                    ok = seal_address();
                else
                    ok = seal_prefix();
                if (ok)
                    pr_phase = PH_PORT;
            end else begin
                ok = 1'b0;
            end
            if (!ok)
                pr_bad = 1'b1;
        end
    endfunction

    // ---------------- text building ----------------
    t_item      text_items[$];
    logic [7:0] text_buf[$];
    int         items_queued = 0;

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.insert(text_buf.size(), s[i]);
    endfunction

    function automatic void push_text();
        foreach (text_buf[i])
            text_items.insert(text_items.size(), t_item'{ACT_CHAR, text_buf[i]});
        // character field of an end item is don't-care; randomize it anyway
        text_items.insert(text_items.size(), t_item'{ACT_END, 8'($urandom_range(0, 255))});
        items_queued += text_buf.size() + 1;
        text_buf.delete();
    endfunction

    function automatic void add_number(int unsigned v, int width);
        logic [7:0]  d[$];
        int unsigned x;
        x = v;
        do begin
            d.push_front(CH_ZERO + 8'(x % 10));
            x = x / 10;
        end while (x != 0);
        while (d.size() < width)
            d.push_front(CH_ZERO);
        foreach (d[i])
            text_buf.insert(text_buf.size(), d[i]);
    endfunction

    function automatic logic [7:0] pick_char();
        string specials;
        specials = "0123456789./:";
        if ($urandom_range(0, 1))
            return specials[$urandom_range(0, specials.len() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    // ---------------- driver ----------------
    int    gap_left = 0;
    int    burst_left = 0;
    t_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                parse_item(in_if.action, in_if.character);
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (text_items.size() != 0) begin
                    next_item = text_items.pop_front();
                    in_if.valid     <= 1'b1;
                    in_if.action    <= next_item.action;
                    in_if.character <= next_item.character;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int   bad_fields = 0;
    int   stall_style = 0;
    int   style_left = 0;
    t_res want;

    function automatic void check_field(string fld, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %0h, got %0h", $time, fld, exp_v, got_v);
            bad_fields++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (parse_results_due.size() == 0) begin
                    $display("%0t: unexpected result valid_res=%0d address=%h prefix=%0d port=%0d",
                             $time, res_if.valid_res, res_if.address_value,
                             res_if.prefix_length, res_if.port_number);
                    bad_fields++;
                end else begin
                    want = parse_results_due.pop_front();
                    check_field("valid_res", 32'(want.valid_res), 32'(res_if.valid_res));
                    check_field("address_value", want.address_value, res_if.address_value);
                    check_field("prefix_length", 32'(want.prefix_length),
                                32'(res_if.prefix_length));
                    check_field("port_number", 32'(want.port_number), 32'(res_if.port_number));
                end
            end
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(20, 200);
            end else begin
                style_left--;
            end
            case (stall_style)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                2:       res_if.ready <= 1'($urandom_range(0, 1));
                default: res_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // ---------------- watchdog ----------------
    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- sequencing ----------------
    task automatic set_reg(t_cfg_idx idx, t_cfg_data val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_ENDPOINT_MODE)
            cfg_mode = val[0];
        else
            cfg_dflt = val;
    endtask

    // all items in, all results out, then let the pipeline drain
    task automatic settle();
        while (text_items.size() != 0 || in_if.valid || parse_results_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_TICKS) @(negedge i_clk);
    endtask

    initial begin
        string       plain_texts[$] = '{"0.0.0.0", "255.255.255.255", "192.168.001.010/24",
                                        "1.2.3.4/0", "10.20.30.40/32", "1.2.3.4/33",
                                        "1.2.3.4/007", "256.1.1.1", "1..2.3", "1.2.3",
                                        "1.2.3.4.5", "1.2.3.4/", "", "1.2.3.4:80",
                                        "1234.1.1.1"};
        string       port_texts[$] = '{"10.0.0.1:1", "10.0.0.1/8:65535", "10.0.0.1:0",
                                       "10.0.0.1:65536", "10.0.0.1:", "10.0.0.1",
                                       "1.2.3.4:5:6", "1.2.3.4:123456", "1.2.3.4/:80",
                                       "1.2.3.4:00080", "1.2.3.4/16"};
        logic        m;
        t_cfg_data   d;
        int          start_cnt;
        int          kind;
        int          r;
        int          len;
        int          pos;
        int unsigned v;
        logic [7:0]  c;

        in_if.valid     = 1'b0;
        in_if.action    = ACT_CHAR;
        in_if.character = '0;
        res_if.ready    = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = CFG_ENDPOINT_MODE;
        i_cfg_data      = '0;
        cfg_mode        = 1'b0;
        cfg_dflt        = 6'd32;
        restart_text();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset configuration: plain address mode, default prefix 32
        foreach (plain_texts[i]) begin
            put_str(plain_texts[i]);
            push_text();
        end
        put_str("1.2.3.4");
        text_buf.insert(text_buf.size(), 8'h00);
        push_text();

        settle();
        set_reg(CFG_ENDPOINT_MODE, t_cfg_data'(1));
        set_reg(CFG_DEFAULT_PREFIX, t_cfg_data'(0));
        @(negedge i_clk);
        foreach (port_texts[i]) begin
            put_str(port_texts[i]);
            push_text();
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            case (ph)
                0:       begin m = 1'b0; d = 6'd0;  end
                1:       begin m = 1'b1; d = 6'd63; end
                2:       begin m = 1'b0; d = 6'd33; end
                3:       begin m = 1'b1; d = 6'd32; end
                default: begin m = 1'($urandom_range(0, 1)); d = 6'($urandom_range(0, 63)); end
            endcase
            // upper data bits are don't-care for the mode register
            set_reg(CFG_ENDPOINT_MODE, {5'($urandom_range(0, 31)), m});
            set_reg(CFG_DEFAULT_PREFIX, d);
            @(negedge i_clk);

            start_cnt = items_queued;
            while (items_queued - start_cnt < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                if (kind < 85) begin
                    for (int k = 0; k < OCTETS; k++) begin
                        if (k != 0)
                            text_buf.insert(text_buf.size(), CH_DOT);
                        r = $urandom_range(0, 99);
                        v = (r < 8) ? $urandom_range(256, 999) :
                            (r < 20) ? (r[0] ? OCTET_MAX : 0) : $urandom_range(0, 255);
                        add_number(v, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0);
                    end
                    if ($urandom_range(0, 9) < 4) begin
                        text_buf.insert(text_buf.size(), CH_SLASH);
                        r = $urandom_range(0, 99);
                        v = (r < 10) ? $urandom_range(33, 99) :
                            (r < 20) ? (r[0] ? PREFIX_MAX : 0) : $urandom_range(0, 32);
                        add_number(v, ($urandom_range(0, 14) == 0) ? $urandom_range(1, 3) : 0);
                    end
                    // mostly a port only where the mode calls for one
                    if (cfg_mode == ($urandom_range(0, 9) != 0)) begin
                        text_buf.insert(text_buf.size(), CH_COLON);
                        r = $urandom_range(0, 99);
                        v = (r < 5) ? 0 :
                            (r < 10) ? $urandom_range(65536, 99999) :
                            (r < 20) ? (r[0] ? PORT_MAX : 1) : $urandom_range(1, 65535);
                        add_number(v, ($urandom_range(0, 11) == 0) ? $urandom_range(1, 6) : 0);
                    end
                    if (kind >= 60) begin
                        pos = $urandom_range(0, text_buf.size() - 1);
                        c   = pick_char();
                        case ($urandom_range(0, 2))
                            0:       text_buf[pos] = c;
                            1:       text_buf.insert(pos, c);
                            default: text_buf.delete(pos);
                        endcase
                    end
                end else begin
                    len = $urandom_range(0, 24);
                    repeat (len) text_buf.insert(text_buf.size(), pick_char());
                end
                push_text();
            end
        end

        settle();
        if (bad_fields == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/ipcp_pkg.sv
design/ipcp_in_if.sv
design/ipcp_res_if.sv
design/ipcp_cfg.sv
design/ipcp_parse.sv
design/ipcp_out_buf.sv
design/ipv4_cidr_endpoint_parser_unit.sv
tb/tb_ipv4_cidr_endpoint_parser_unit.sv
